/* rtl/core/tga_stream_pixel_decoder_defines.svh */
// ---------------------------------------------------------------------------
// TGA stream pixel decoder: assertion macros
// Shared macros for the concurrent assertions of the decoder modules.
// ---------------------------------------------------------------------------
`ifndef TGA_STREAM_PIXEL_DECODER_DEFINES_SVH
`define TGA_STREAM_PIXEL_DECODER_DEFINES_SVH

// Checked on every rising edge of clk_i outside reset.
`define TSPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define TSPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/tspd_pkg.sv */
// ---------------------------------------------------------------------------
// TGA stream pixel decoder package
// Types, codes and constants shared by the decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tspd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  localparam int unsigned HDR_LEN = 18;

  localparam logic [1:0] KIND_INFO  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CMAP      = 3'd2;
  localparam logic [2:0] ST_TYPE      = 3'd3;
  localparam logic [2:0] ST_ALPHA     = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  localparam logic [7:0] CMAP_ABSENT      = 8'd0;
  localparam logic [7:0] TYPE_TRUE_COLOUR = 8'd2;
  localparam logic [7:0] TYPE_GREY        = 8'd3;
  localparam logic [7:0] BPP_TRUE         = 8'd24;
  localparam logic [7:0] BPP_GRAY         = 8'd8;
  localparam logic [7:0] ALPHA_MASK       = 8'h0f;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [16:0] frame_width;
    logic [16:0] frame_height;
    logic [16:0] out_x;
    logic [16:0] out_row;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       main_vld;
    result_t    main;
    logic       eof_vld;
    logic [2:0] eof_status;
  } record_t;

endpackage

`default_nettype wire

/* rtl/core/tspd_result_queue.sv */
// ---------------------------------------------------------------------------
// TGA stream pixel decoder result queue
// Two-record queue splitting each record into results, one per unstalled cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tga_stream_pixel_decoder_defines.svh"

module tspd_result_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tspd_pkg::record_t push_rec_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tspd_pkg::result_t      out_res_o
);

  tspd_pkg::record_t rec_q [2];
  tspd_pkg::record_t head;
  logic [1:0]        count_q;
  logic              wr_q;
  logic              rd_q;
  logic              fire;
  logic              pop;

  assign head        = rec_q[rd_q];
  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign fire        = out_valid_o && !out_stall_i;
  assign pop         = fire && !(head.main_vld && head.eof_vld);

  always_comb begin
    if (head.main_vld) begin
      out_res_o      = head.main;
      out_res_o.last = !head.eof_vld;
    end else begin
      out_res_o        = '0;
      out_res_o.kind   = tspd_pkg::KIND_END;
      out_res_o.status = head.eof_status;
      out_res_o.last   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rec_q[wr_q] <= push_rec_i;
    end
    if (fire && !pop) begin
      rec_q[rd_q].main_vld <= 1'b0;
    end
  end

  `TSPD_ASSERT(a_no_push_when_full, push_i |-> !full_o, "push into a full result queue")
  `TSPD_ASSERT_ALWAYS(a_count_in_range, (!rst_ni || count_q != 2'd3), "result queue count out of range")
  `TSPD_ASSERT(a_split_shows_end,
    (fire && !pop) |=> (out_valid_o && out_res_o.kind == tspd_pkg::KIND_END && out_res_o.last),
    "end status did not follow the first result of a record")
  `TSPD_ASSERT(a_count_drops,
    (pop && !push_i) |=> (count_q == $past(count_q) - 2'd1),
    "queue count did not fall after the last result of a record")

endmodule

`default_nettype wire

/* rtl/core/tga_stream_pixel_decoder.sv */
// ---------------------------------------------------------------------------
// TGA stream pixel decoder
// Streaming decoder for uncompressed 24 bpp true-colour and 8 bpp grey TGA.
// ---------------------------------------------------------------------------
// The block takes one file byte per input transaction and can accept a byte
// in every cycle; each byte is decoded in the cycle it is accepted and its
// results enter a two-record output queue, so the input keeps flowing while
// one record waits to be taken and stalls only while two records wait. The
// output port delivers one result per cycle while out_stall_i is low: a byte
// that yields both a frame-info or pixel result and an end status gives two
// results, the info or pixel result first, and every other byte at most one.
// The first result appears at the earliest in the cycle after acceptance.
// After the byte flagged end_of_file the decoder expects a new header.
`default_nettype none

`include "tga_stream_pixel_decoder_defines.svh"

module tga_stream_pixel_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [2:0]       status_o,
  output logic [16:0]      frame_width_o,
  output logic [16:0]      frame_height_o,
  output logic [16:0]      out_x_o,
  output logic [16:0]      out_row_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       green_o,
  output logic [7:0]       red_o,
  output logic             last_of_run_o
);

  tspd_pkg::phase_e  phase_q, phase_d;
  logic [4:0]        hdr_idx_q, hdr_idx_d;
  logic [7:0]        hdr_q [tspd_pkg::HDR_LEN];
  logic [21:0]       skip_q, skip_d;
  logic [15:0]       col_q, col_d;
  logic [15:0]       row_q, row_d;
  logic [1:0]        chan_q, chan_d;
  logic [7:0]        held_b_q, held_b_d;
  logic [7:0]        held_g_q, held_g_d;
  logic [2:0]        err_q, err_d;

  logic              in_acc;
  logic              full;
  tspd_pkg::record_t rec;
  tspd_pkg::result_t out_res;

  logic [15:0]       img_w, img_h, org_x, org_y, cmap_len;
  logic [23:0]       cmap_bits;
  logic [24:0]       cmap_bits_rnd;
  logic [21:0]       skip_sum;
  logic [21:0]       skip_dec;
  logic [2:0]        hdr_err;
  logic [15:0]       col_inc, row_inc;
  logic              have_px;
  logic [7:0]        px_b, px_g, px_r;
  tspd_pkg::phase_e  next_after_skip;

  function automatic logic [2:0] check_hdr(input logic [7:0] map_code,
                                           input logic [7:0] image_code,
                                           input logic [7:0] bpp,
                                           input logic [7:0] desc);
    logic [2:0] st;
    st = tspd_pkg::ST_OK;
    if (map_code != tspd_pkg::CMAP_ABSENT) begin
      st = tspd_pkg::ST_CMAP;
    end else if (image_code == tspd_pkg::TYPE_TRUE_COLOUR) begin
      if (bpp != tspd_pkg::BPP_TRUE) begin
        st = tspd_pkg::ST_TYPE;
      end
    end else if (image_code == tspd_pkg::TYPE_GREY) begin
      if (bpp != tspd_pkg::BPP_GRAY) begin
        st = tspd_pkg::ST_TYPE;
      end
    end else begin
      st = tspd_pkg::ST_TYPE;
    end
    if (st == tspd_pkg::ST_OK && (desc & tspd_pkg::ALPHA_MASK) != 8'd0) begin
      st = tspd_pkg::ST_ALPHA;
    end
    return st;
  endfunction

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = full;

  assign org_x    = {hdr_q[9], hdr_q[8]};
  assign org_y    = {hdr_q[11], hdr_q[10]};
  assign img_w    = {hdr_q[13], hdr_q[12]};
  assign img_h    = {hdr_q[15], hdr_q[14]};
  assign cmap_len = {hdr_q[6], hdr_q[5]};

  assign cmap_bits     = 24'(cmap_len) * 24'(hdr_q[7]);
  assign cmap_bits_rnd = {1'b0, cmap_bits} + 25'd7;
  assign skip_sum      = 22'(cmap_bits_rnd >> 3) + 22'(hdr_q[0]);
  assign skip_dec      = (skip_q != 22'd0) ? (skip_q - 22'd1) : skip_q;
  assign hdr_err       = check_hdr(hdr_q[1], hdr_q[2], hdr_q[16], in_byte_i);
  assign col_inc       = col_q + 16'd1;
  assign row_inc       = row_q + 16'd1;

  assign next_after_skip = (img_w != 16'd0 && img_h != 16'd0) ? tspd_pkg::PH_PIXELS
                                                              : tspd_pkg::PH_DONE;

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    skip_d    = skip_q;
    col_d     = col_q;
    row_d     = row_q;
    chan_d    = chan_q;
    held_b_d  = held_b_q;
    held_g_d  = held_g_q;
    err_d     = err_q;
    rec       = '0;
    have_px   = 1'b0;
    px_b      = in_byte_i;
    px_g      = in_byte_i;
    px_r      = in_byte_i;

    unique case (phase_q)
      tspd_pkg::PH_HEADER: begin
        hdr_idx_d = hdr_idx_q + 5'd1;
        if (hdr_idx_q == 5'(tspd_pkg::HDR_LEN - 1)) begin
          rec.main_vld          = 1'b1;
          rec.main.kind         = tspd_pkg::KIND_INFO;
          rec.main.status       = hdr_err;
          rec.main.frame_width  = {1'b0, org_x} + {1'b0, img_w};
          rec.main.frame_height = {1'b0, org_y} + {1'b0, img_h};
          err_d  = hdr_err;
          skip_d = skip_sum;
          col_d  = 16'd0;
          row_d  = 16'd0;
          chan_d = 2'd0;
          if (hdr_err != tspd_pkg::ST_OK) begin
            phase_d = tspd_pkg::PH_DONE;
          end else if (skip_sum != 22'd0) begin
            phase_d = tspd_pkg::PH_SKIP;
          end else begin
            phase_d = next_after_skip;
          end
        end
      end
      tspd_pkg::PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 22'd0) begin
          phase_d = next_after_skip;
        end
      end
      tspd_pkg::PH_PIXELS: begin
        if (hdr_q[2] == tspd_pkg::TYPE_GREY) begin
          have_px = 1'b1;
        end else if (chan_q == 2'd0) begin
          held_b_d = in_byte_i;
          chan_d   = 2'd1;
        end else if (chan_q == 2'd1) begin
          held_g_d = in_byte_i;
          chan_d   = 2'd2;
        end else begin
          px_b    = held_b_q;
          px_g    = held_g_q;
          chan_d  = 2'd0;
          have_px = 1'b1;
        end
        if (have_px) begin
          rec.main_vld     = 1'b1;
          rec.main.kind    = tspd_pkg::KIND_PIXEL;
          rec.main.out_x   = {1'b0, org_x} + {1'b0, col_q};
          rec.main.out_row = {1'b0, img_h - 16'd1 - row_q};
          rec.main.blue    = px_b;
          rec.main.green   = px_g;
          rec.main.red     = px_r;
          col_d = col_inc;
          if (col_inc >= img_w) begin
            col_d = 16'd0;
            row_d = row_inc;
            if (row_inc >= img_h) begin
              phase_d = tspd_pkg::PH_DONE;
            end
          end
        end
      end
      tspd_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (end_of_file_i) begin
      rec.eof_vld = 1'b1;
      if (phase_d == tspd_pkg::PH_HEADER) begin
        rec.eof_status = tspd_pkg::ST_SHORT;
      end else if (phase_d == tspd_pkg::PH_DONE) begin
        rec.eof_status = err_d;
      end else begin
        rec.eof_status = tspd_pkg::ST_TRUNCATED;
      end
      phase_d   = tspd_pkg::PH_HEADER;
      hdr_idx_d = 5'd0;
      skip_d    = 22'd0;
      col_d     = 16'd0;
      row_d     = 16'd0;
      chan_d    = 2'd0;
      held_b_d  = 8'd0;
      held_g_d  = 8'd0;
      err_d     = tspd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tspd_pkg::PH_HEADER;
      hdr_idx_q <= 5'd0;
      skip_q    <= 22'd0;
      col_q     <= 16'd0;
      row_q     <= 16'd0;
      chan_q    <= 2'd0;
      held_b_q  <= 8'd0;
      held_g_q  <= 8'd0;
      err_q     <= tspd_pkg::ST_OK;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      skip_q    <= skip_d;
      col_q     <= col_d;
      row_q     <= row_d;
      chan_q    <= chan_d;
      held_b_q  <= held_b_d;
      held_g_q  <= held_g_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && phase_q == tspd_pkg::PH_HEADER) begin
      hdr_q[hdr_idx_q] <= in_byte_i;
    end
  end

  tspd_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && (rec.main_vld || rec.eof_vld)),
    .push_rec_i  (rec),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign kind_o         = out_res.kind;
  assign status_o       = out_res.status;
  assign frame_width_o  = out_res.frame_width;
  assign frame_height_o = out_res.frame_height;
  assign out_x_o        = out_res.out_x;
  assign out_row_o      = out_res.out_row;
  assign blue_o         = out_res.blue;
  assign green_o        = out_res.green;
  assign red_o          = out_res.red;
  assign last_of_run_o  = out_res.last;

  `TSPD_ASSERT(a_eof_restarts,
    (in_acc && end_of_file_i) |=> (phase_q == tspd_pkg::PH_HEADER && hdr_idx_q == 5'd0),
    "decoder did not restart after the end of file")
  `TSPD_ASSERT(a_pixel_position,
    (phase_q == tspd_pkg::PH_PIXELS) |-> (col_q < img_w && row_q < img_h),
    "pixel position outside the image")
  `TSPD_ASSERT(a_header_index,
    (phase_q == tspd_pkg::PH_HEADER) |-> (hdr_idx_q < 5'(tspd_pkg::HDR_LEN)),
    "header index beyond the header length")

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TGA stream pixel decoder testbench
// Sends short TGA files byte by byte and checks every frame-info, pixel and
// end-status result against a decoder model kept in the bench.
// ---------------------------------------------------------------------------
// Directed files cover the header checks, short headers, truncation, exact
// ends, trailing bytes, empty images and the frame extremes. Random files,
// mostly well formed with random content, follow. Both sides stall at random
// in two of three regimes; at times the sender waits for the output to drain.

module tb;

  typedef struct packed {
    logic [7:0]  id_len;
    logic [7:0]  map_code;
    logic [7:0]  image_code;
    logic [15:0] cmap_first;
    logic [15:0] cmap_len;
    logic [7:0]  cmap_bits;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  bpp;
    logic [7:0]  desc;
  } tga_hdr_t;

  typedef struct {
    logic [7:0] data;
    logic       eof;
    bit         drain;
  } file_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'd0;
  logic        in_eof = 1'b0;
  logic        out_stall = 1'b1;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [2:0]  status_o;
  logic [16:0] frame_width_o;
  logic [16:0] frame_height_o;
  logic [16:0] out_x_o;
  logic [16:0] out_row_o;
  logic [7:0]  blue_o;
  logic [7:0]  green_o;
  logic [7:0]  red_o;
  logic        last_of_run_o;

  file_byte_t          byte_queue[$];
  tspd_pkg::result_t   expected_results[$];
  logic                byte_taken = 1'b0;
  int unsigned         bytes_total = 1;
  int unsigned         bytes_taken = 0;
  int unsigned         files_queued = 0;
  int unsigned         results_checked = 0;
  int unsigned         mismatches = 0;

  // Decoder model state.
  tspd_pkg::phase_e dec_phase;
  logic [4:0]       hdr_idx;
  logic [7:0]       hdr_bytes [tspd_pkg::HDR_LEN];
  logic [21:0]      skip_left;
  logic [15:0]      col;
  logic [15:0]      row;
  logic [1:0]       chan;
  logic [7:0]       held_b;
  logic [7:0]       held_g;
  logic [2:0]       hdr_status;

  tga_stream_pixel_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte),
    .end_of_file_i  (in_eof),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .frame_width_o  (frame_width_o),
    .frame_height_o (frame_height_o),
    .out_x_o        (out_x_o),
    .out_row_o      (out_row_o),
    .blue_o         (blue_o),
    .green_o        (green_o),
    .red_o          (red_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] hword(input logic [4:0] i);
    return {hdr_bytes[i + 5'd1], hdr_bytes[i]};
  endfunction

  function automatic tspd_pkg::phase_e image_phase();
    if (hword(5'd12) != 16'd0 && hword(5'd14) != 16'd0) begin
      return tspd_pkg::PH_PIXELS;
    end
    return tspd_pkg::PH_DONE;
  endfunction

  task automatic reset_decoder();
    dec_phase = tspd_pkg::PH_HEADER;
    hdr_idx = 5'd0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = 8'd0;
    skip_left = '0;
    col = '0;
    row = '0;
    chan = '0;
    held_b = '0;
    held_g = '0;
    hdr_status = tspd_pkg::ST_OK;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    tspd_pkg::result_t res [$];
    tspd_pkg::result_t r;
    logic [31:0]       map_bits;
    logic [7:0]        pb;
    logic [7:0]        pg;
    logic [7:0]        pr;
    bit                have;
    if (dec_phase == tspd_pkg::PH_HEADER) begin
      hdr_bytes[hdr_idx] = b;
      hdr_idx++;
      if (hdr_idx >= 5'(tspd_pkg::HDR_LEN)) begin
        map_bits = 32'(hword(5'd5)) * 32'(hdr_bytes[7]);
        if (hdr_bytes[1] != tspd_pkg::CMAP_ABSENT) begin
          hdr_status = tspd_pkg::ST_CMAP;
        end else if (!((hdr_bytes[2] == tspd_pkg::TYPE_TRUE_COLOUR &&
                        hdr_bytes[16] == tspd_pkg::BPP_TRUE) ||
                       (hdr_bytes[2] == tspd_pkg::TYPE_GREY &&
                        hdr_bytes[16] == tspd_pkg::BPP_GRAY))) begin
          hdr_status = tspd_pkg::ST_TYPE;
        end else if ((hdr_bytes[17] & tspd_pkg::ALPHA_MASK) != 8'd0) begin
          hdr_status = tspd_pkg::ST_ALPHA;
        end else begin
          hdr_status = tspd_pkg::ST_OK;
        end
        r = '0;
        r.kind = tspd_pkg::KIND_INFO;
        r.status = hdr_status;
        r.frame_width = {1'b0, hword(5'd8)} + {1'b0, hword(5'd12)};
        r.frame_height = {1'b0, hword(5'd10)} + {1'b0, hword(5'd14)};
        res.push_back(r);
        skip_left = 22'(32'(hdr_bytes[0]) + ((map_bits + 32'd7) >> 3));
        col = '0;
        row = '0;
        chan = '0;
        if (hdr_status != tspd_pkg::ST_OK) begin
          dec_phase = tspd_pkg::PH_DONE;
        end else if (skip_left != '0) begin
          dec_phase = tspd_pkg::PH_SKIP;
        end else begin
          dec_phase = image_phase();
        end
      end
    end else if (dec_phase == tspd_pkg::PH_SKIP) begin
      if (skip_left != '0) skip_left--;
      if (skip_left == '0) dec_phase = image_phase();
    end else if (dec_phase == tspd_pkg::PH_PIXELS) begin
      have = 1'b0;
      pb = b;
      pg = b;
      pr = b;
      if (hdr_bytes[2] == tspd_pkg::TYPE_GREY) begin
        have = 1'b1;
      end else if (chan == 2'd0) begin
        held_b = b;
        chan = 2'd1;
      end else if (chan == 2'd1) begin
        held_g = b;
        chan = 2'd2;
      end else begin
        pb = held_b;
        pg = held_g;
        chan = 2'd0;
        have = 1'b1;
      end
      if (have) begin
        r = '0;
        r.kind = tspd_pkg::KIND_PIXEL;
        r.out_x = {1'b0, hword(5'd8)} + {1'b0, col};
        r.out_row = {1'b0, hword(5'd14) - 16'd1 - row};
        r.blue = pb;
        r.green = pg;
        r.red = pr;
        res.push_back(r);
        col++;
        if (col >= hword(5'd12)) begin
          col = '0;
          row++;
          if (row >= hword(5'd14)) dec_phase = tspd_pkg::PH_DONE;
        end
      end
    end
    if (eof) begin
      r = '0;
      r.kind = tspd_pkg::KIND_END;
      if (dec_phase == tspd_pkg::PH_HEADER) begin
        r.status = tspd_pkg::ST_SHORT;
      end else if (dec_phase == tspd_pkg::PH_DONE) begin
        r.status = hdr_status;
      end else begin
        r.status = tspd_pkg::ST_TRUNCATED;
      end
      res.push_back(r);
      reset_decoder();
    end
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  function automatic tga_hdr_t plain_hdr(input logic [7:0] img, input logic [15:0] w,
                                         input logic [15:0] h);
    tga_hdr_t t;
    t = '0;
    t.image_code = img;
    t.bpp = (img == tspd_pkg::TYPE_TRUE_COLOUR) ? tspd_pkg::BPP_TRUE : tspd_pkg::BPP_GRAY;
    t.w = w;
    t.h = h;
    return t;
  endfunction

  function automatic int unsigned file_length(input tga_hdr_t t);
    int unsigned bpc;
    bpc = 0;
    if (t.map_code == tspd_pkg::CMAP_ABSENT && (t.desc & tspd_pkg::ALPHA_MASK) == 8'd0) begin
      if (t.image_code == tspd_pkg::TYPE_TRUE_COLOUR && t.bpp == tspd_pkg::BPP_TRUE) bpc = 3;
      if (t.image_code == tspd_pkg::TYPE_GREY && t.bpp == tspd_pkg::BPP_GRAY) bpc = 1;
    end
    if (bpc == 0) return tspd_pkg::HDR_LEN;
    return tspd_pkg::HDR_LEN + 32'(t.id_len)
           + (32'(t.cmap_len) * 32'(t.cmap_bits) + 32'd7) / 32'd8
           + 32'(t.w) * 32'(t.h) * bpc;
  endfunction

  task automatic queue_file(input tga_hdr_t t, input int unsigned n_bytes, input bit drain);
    logic [7:0] head [tspd_pkg::HDR_LEN];
    file_byte_t fb;
    head = '{t.id_len, t.map_code, t.image_code, t.cmap_first[7:0], t.cmap_first[15:8],
             t.cmap_len[7:0], t.cmap_len[15:8], t.cmap_bits, t.x0[7:0], t.x0[15:8],
             t.y0[7:0], t.y0[15:8], t.w[7:0], t.w[15:8], t.h[7:0], t.h[15:8],
             t.bpp, t.desc};
    for (int unsigned i = 0; i < n_bytes; i++) begin
      fb.data = (i < tspd_pkg::HDR_LEN) ? head[5'(i)] : 8'($urandom);
      fb.eof = (i == n_bytes - 1);
      fb.drain = drain && (i == 0);
      byte_queue.push_back(fb);
    end
    files_queued++;
  endtask

  function automatic tga_hdr_t random_hdr();
    tga_hdr_t t;
    t = plain_hdr($urandom_range(0, 1) ? tspd_pkg::TYPE_GREY : tspd_pkg::TYPE_TRUE_COLOUR,
                  16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)));
    if ($urandom_range(0, 19) == 0) begin
      t.w = 16'($urandom_range(6, 40));
      t.h = 16'($urandom_range(1, 2));
    end
    t.cmap_first = 16'($urandom);
    if ($urandom_range(0, 3) == 0) t.id_len = 8'($urandom_range(1, 4));
    if ($urandom_range(0, 3) == 0) begin
      t.cmap_len = 16'($urandom_range(1, 3));
      t.cmap_bits = 8'($urandom);
    end
    if ($urandom_range(0, 2) == 0) begin
      t.x0 = 16'($urandom);
      t.y0 = 16'($urandom);
    end else begin
      t.x0 = 16'($urandom_range(0, 3));
      t.y0 = 16'($urandom_range(0, 3));
    end
    t.desc = {4'($urandom), 4'd0};
    case ($urandom_range(0, 19))
      0: t.map_code = 8'($urandom_range(1, 255));
      1: t.image_code = 8'($urandom);
      2: t.bpp = 8'($urandom);
      3: t.desc[3:0] = 4'($urandom_range(1, 15));
      default: ;
    endcase
    return t;
  endfunction

  always @(negedge clk_i) begin : drive
    int unsigned stage;
    int unsigned sender_idle;
    int unsigned receiver_idle;
    logic        next_valid;
    file_byte_t  fb;
    if (rst_ni) begin
      stage = (bytes_taken * 3) / bytes_total;
      sender_idle = (stage == 0) ? 26 : (stage == 1) ? 84 : 0;
      receiver_idle = (stage == 0) ? 84 : (stage == 1) ? 26 : 0;
      if (!in_valid || byte_taken) begin
        next_valid = 1'b0;
        if (byte_queue.size() != 0 &&
            !(byte_queue[0].drain && expected_results.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle) begin
          fb = byte_queue.pop_front();
          in_byte <= fb.data;
          in_eof <= fb.eof;
          next_valid = 1'b1;
        end
        in_valid <= next_valid;
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle);
    end
  end

  always @(posedge clk_i) begin : monitor
    tspd_pkg::result_t want;
    if (rst_ni) begin
      byte_taken <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) begin
        decode_byte(in_byte, in_eof);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("unexpected result: kind %0d, status %0d", kind_o, status_o);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("frame_width", 32'(want.frame_width), 32'(frame_width_o));
          check_field("frame_height", 32'(want.frame_height), 32'(frame_height_o));
          check_field("out_x", 32'(want.out_x), 32'(out_x_o));
          check_field("out_row", 32'(want.out_row), 32'(out_row_o));
          check_field("blue", 32'(want.blue), 32'(blue_o));
          check_field("green", 32'(want.green), 32'(green_o));
          check_field("red", 32'(want.red), 32'(red_o));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run_o));
        end
      end
    end
  end

  initial begin : stimulus
    tga_hdr_t    t;
    int unsigned full;
    int unsigned n_bytes;
    reset_decoder();

    t = plain_hdr(tspd_pkg::TYPE_TRUE_COLOUR, 16'd1, 16'd1);
    queue_file(t, file_length(t), 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd2, 16'd2);
    t.x0 = 16'hFFFF;
    t.y0 = 16'hFFFF;
    queue_file(t, file_length(t), 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd3, 16'd2);
    t.y0 = 16'd3;
    queue_file(t, file_length(t) + 3, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'hFFFF, 16'hFFFF);
    t.x0 = 16'hFFFF;
    t.y0 = 16'hFFFF;
    queue_file(t, tspd_pkg::HDR_LEN + 5, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_TRUE_COLOUR, 16'd2, 16'd1);
    t.desc = 8'hF0;
    queue_file(t, tspd_pkg::HDR_LEN + 4, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_TRUE_COLOUR, 16'd2, 16'd1);
    t.id_len = 8'd2;
    t.cmap_len = 16'd3;
    t.cmap_bits = 8'd15;
    queue_file(t, file_length(t), 1'b1);
    t = plain_hdr(tspd_pkg::TYPE_TRUE_COLOUR, 16'd1, 16'd1);
    t.id_len = 8'hFF;
    t.cmap_len = 16'hFFFF;
    t.cmap_bits = 8'hFF;
    queue_file(t, 40, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd0, 16'd5);
    queue_file(t, tspd_pkg::HDR_LEN, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd4, 16'd0);
    t.id_len = 8'd3;
    queue_file(t, tspd_pkg::HDR_LEN + 3, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd4, 16'd1);
    t.id_len = 8'd3;
    queue_file(t, tspd_pkg::HDR_LEN, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_TRUE_COLOUR, 16'd1, 16'd1);
    queue_file(t, tspd_pkg::HDR_LEN, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd1, 16'd1);
    queue_file(t, 1, 1'b0);
    queue_file(t, tspd_pkg::HDR_LEN - 1, 1'b0);
    t.map_code = 8'd1;
    t.image_code = 8'd10;
    queue_file(t, tspd_pkg::HDR_LEN + 2, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_TRUE_COLOUR, 16'd1, 16'd1);
    t.bpp = tspd_pkg::BPP_GRAY;
    queue_file(t, tspd_pkg::HDR_LEN, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd1, 16'd1);
    t.bpp = tspd_pkg::BPP_TRUE;
    t.desc = 8'h0F;
    queue_file(t, tspd_pkg::HDR_LEN + 2, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd1, 16'd1);
    t.image_code = 8'd10;
    queue_file(t, tspd_pkg::HDR_LEN + 1, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_GREY, 16'd1, 16'd1);
    t.desc = 8'h0F;
    queue_file(t, tspd_pkg::HDR_LEN + 2, 1'b0);
    t = plain_hdr(tspd_pkg::TYPE_TRUE_COLOUR, 16'd1, 16'd1);
    t.desc = 8'h08;
    queue_file(t, tspd_pkg::HDR_LEN, 1'b0);

    while (byte_queue.size() < 900) begin
      t = random_hdr();
      if ($urandom_range(0, 99) < 12) begin
        t.id_len = 8'($urandom);
        t.map_code = 8'($urandom);
        t.image_code = 8'($urandom);
        t.cmap_len = 16'($urandom);
        t.cmap_bits = 8'($urandom);
        t.w = 16'($urandom);
        t.h = 16'($urandom);
        t.bpp = 8'($urandom);
        t.desc = 8'($urandom);
        n_bytes = $urandom_range(1, 30);
      end else begin
        full = file_length(t);
        if ($urandom_range(0, 99) < 70) begin
          n_bytes = full + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        end else begin
          n_bytes = $urandom_range(1, full);
        end
      end
      queue_file(t, n_bytes, $urandom_range(0, 11) == 0);
    end
    bytes_total = byte_queue.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $error("%0d expected results never arrived", expected_results.size());
    end

    $display("Covered %0d files (%0d bytes) and checked %0d results under three stall regimes.",
             files_queued, bytes_taken, results_checked);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: errors");
    $finish;
  end

endmodule
